// File: design/text_mode_terminal_renderer_defines.svh
// Assertion helpers for the text-mode terminal renderer.
`ifndef TEXT_MODE_TERMINAL_RENDERER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_RENDERER_DEFINES_SVH

// Assert a property on the rising clock edge, disabled while in reset.
`define TMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a signal is one-hot or all zero, disabled while in reset.
`define TMT_ONEHOT0(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) $onehot0(sig)) else $error(msg);

`endif

// File: design/tmt_pkg.sv
package tmt_pkg;

  localparam int GlyphHeight = 8;
  localparam logic [7:0] SpaceCode = 8'd32;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_RENDER = 2'd1,
    MODE_FONT   = 2'd2,
    MODE_PAL    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_COLS   = 3'd0,
    REG_ROWS   = 3'd1,
    REG_SCROLL = 3'd2,
    REG_FG     = 3'd3,
    REG_BG     = 3'd4,
    REG_FIRST  = 3'd5,
    REG_LAST   = 3'd6
  } reg_idx_t;

  // Status handed from the address unit to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } addr_stat_t;

endpackage

// File: design/text_mode_terminal_renderer.sv
// Sequence: a write passes the address unit and the screen store, then gives one result;
//   a load, or an off-screen write as a load, gives its one result directly. A render
//   gives four results, each held until taken. No request is accepted until the last
//   result is taken; a scrolling write first moves the rows up and blanks the last row.
// Reset: cursor home, registers to their defaults, then a clearing pass over all
//   MAX_COLUMNS*MAX_ROWS cells of the screen store during which no request is accepted.
`include "text_mode_terminal_renderer_defines.svh"
module text_mode_terminal_renderer #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS = 30,
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code[7:0], scan_line[15:8], text_column[22:16], font_address[33:23],
  // font_bits[41:34], palette_slot[45:42], palette_color[61:46]
  input  logic [63:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_left[15:0], pixel_right[31:16]
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  // status[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tmt_pkg::*;

  localparam int Cells = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(Cells);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_ADDR   = 12'b000000000100,
    S_CELL   = 12'b000000001000,
    S_FONT   = 12'b000000010000,
    S_PIX    = 12'b000000100000,
    S_EMIT   = 12'b000001000000,
    S_SRD    = 12'b000010000000,
    S_SWR    = 12'b000100000000,
    S_FILL   = 12'b001000000000,
    S_WAIT   = 12'b010000000000,
    S_ONE    = 12'b100000000000
  } state_t;

  state_t state;

  logic [6:0] columns_in_use;
  logic [4:0] rows_in_use;
  logic       scroll_enable;
  logic [3:0] foreground_index, background_index;
  logic [7:0] first_glyph, last_glyph;

  logic [15:0] screen [Cells];
  logic [7:0]  font [2048];
  logic [15:0] palette [16];

  logic [6:0] cur_col;
  logic [4:0] cur_row;

  // latched item
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [4:0]  trow;
  logic [2:0]  crow;
  logic [6:0]  tcol;
  logic        ok;

  logic [6:0] cols;
  logic [4:0] rows;
  always_comb begin
    cols = (columns_in_use == 7'd0) ? 7'd1 :
      ((32'(columns_in_use) > MAX_COLUMNS) ? 7'(MAX_COLUMNS) : columns_in_use);
    rows = (rows_in_use == 5'd0) ? 5'd1 :
      ((32'(rows_in_use) > MAX_ROWS) ? 5'(MAX_ROWS) : rows_in_use);
  end

  // address unit inputs
  logic          au_start;
  logic [4:0]    au_row;
  logic [6:0]    au_col;
  logic [AW-1:0] au_addr;
  addr_stat_t    au_stat;

  tmt_addr_unit #(.AW(AW)) u_addr (
    .clk(clk), .rst(rst), .start(au_start), .row(au_row), .cols(cols),
    .col(au_col), .addr(au_addr), .stat(au_stat)
  );

  logic [AW-1:0] clr_ptr;
  logic [AW-1:0] sc_ptr;   // scroll destination
  logic [AW-1:0] sc_end;   // (rows-1)*cols
  logic [AW-1:0] sc_total; // rows*cols
  logic [15:0]   cell_q;
  logic [15:0]   sc_data;
  logic [7:0]    bits;
  logic [15:0]   fgc, bgc;
  logic [1:0]    k;
  logic          status;

  // address unit holds (rows-1)*cols for the whole scroll
  assign sc_end = au_addr;
  assign sc_total = au_addr + AW'(cols);

  logic in_fire, out_fire;
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  logic [15:0] cur_cell;
  assign cur_cell = {background_index, foreground_index, char_code};
  logic [15:0] space_cell;
  assign space_cell = {background_index, foreground_index, SpaceCode};

  logic [3:0] fi, bi;
  logic       at_cur;
  logic       in_glyph;
  assign fi = cell_q[11:8];
  assign bi = cell_q[15:12];
  assign at_cur = (cur_col == tcol) && (cur_row == trow);
  assign in_glyph = (cell_q[7:0] >= first_glyph) && (cell_q[7:0] <= last_glyph);

  function automatic logic [15:0] pal_rd(input logic [15:0] v, input logic [3:0] idx);
    return (32'(idx) < PALETTE_ENTRIES) ? v : 16'd0;
  endfunction

  logic [3:0] fsel, bsel;
  assign fsel = at_cur ? bi : fi;
  assign bsel = at_cur ? fi : bi;

  // address unit control
  always_comb begin
    au_start = 1'b0;
    au_row = trow;
    au_col = tcol;
    if (state == S_ADDR) begin
      au_start = 1'b1;
      if (mode == MODE_WRITE) begin
        au_row = cur_row;
        au_col = cur_col;
      end
    end else if (state == S_WAIT) begin
      // scroll region bounds
      au_start = 1'b1;
      au_row = rows - 5'd1;
      au_col = 7'd0;
    end
  end

  logic [1:0] sh;
  assign sh = 2'd3 - k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_ptr <= '0;
      cur_col <= '0;
      cur_row <= '0;
      columns_in_use <= 7'd80;
      rows_in_use <= 5'd30;
      scroll_enable <= 1'b1;
      foreground_index <= 4'd15;
      background_index <= 4'd0;
      first_glyph <= 8'd32;
      last_glyph <= 8'd126;
      m_tvalid <= 1'b0;
      k <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_COLS:   columns_in_use <= cfg_data[6:0];
          REG_ROWS:   rows_in_use <= cfg_data[4:0];
          REG_SCROLL: scroll_enable <= cfg_data[0];
          REG_FG:     foreground_index <= cfg_data[3:0];
          REG_BG:     background_index <= cfg_data[3:0];
          REG_FIRST:  first_glyph <= cfg_data;
          REG_LAST:   last_glyph <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          screen[clr_ptr] <= '0;
          if (32'(clr_ptr) == Cells - 1) state <= S_IDLE;
          clr_ptr <= clr_ptr + AW'(1);
        end
        S_IDLE: begin
          if (in_fire) begin
            mode <= s_tuser;
            char_code <= s_tdata[7:0];
            trow <= s_tdata[15:11];
            crow <= s_tdata[10:8];
            tcol <= s_tdata[22:16];
            k <= '0;
            unique case (mode_t'(s_tuser))
              MODE_WRITE: begin
                if (cur_col >= cols || cur_row >= rows) begin
                  cur_col <= '0;
                  cur_row <= '0;
                  status <= 1'b1;
                  state <= S_ONE;
                end else begin
                  state <= S_ADDR;
                end
              end
              MODE_RENDER: begin
                ok <= (s_tdata[15:11] < rows) && (s_tdata[22:16] < cols);
                state <= S_ADDR;
              end
              MODE_FONT: begin
                font[s_tdata[33:23]] <= s_tdata[41:34];
                status <= 1'b0;
                state <= S_ONE;
              end
              MODE_PAL: begin
                if (32'(s_tdata[45:42]) < PALETTE_ENTRIES) begin
                  palette[s_tdata[45:42]] <= s_tdata[61:46];
                  status <= 1'b0;
                end else begin
                  status <= 1'b1;
                end
                state <= S_ONE;
              end
              default: ;
            endcase
          end
        end
        S_ADDR: state <= S_CELL;
        S_CELL: begin
          if (mode == MODE_WRITE) begin
            screen[au_addr] <= cur_cell;
            status <= 1'b0;
            if (32'(cur_col) + 1 < 32'(cols)) begin
              cur_col <= cur_col + 7'd1;
              state <= S_ONE;
            end else begin
              cur_col <= '0;
              if (32'(cur_row) + 1 < 32'(rows)) begin
                cur_row <= cur_row + 5'd1;
                state <= S_ONE;
              end else if (scroll_enable) begin
                cur_row <= rows - 5'd1;
                state <= S_WAIT;
              end else begin
                cur_row <= '0;
                state <= S_ONE;
              end
            end
          end else begin
            cell_q <= screen[au_addr];
            state <= S_FONT;
          end
        end
        S_WAIT: begin
          sc_ptr <= '0;
          // a single row has nothing to move, only the fill
          state <= (rows == 5'd1) ? S_FILL : S_SRD;
        end
        S_SRD: begin
          sc_data <= screen[sc_ptr + AW'(cols)];
          state <= S_SWR;
        end
        S_SWR: begin
          screen[sc_ptr] <= sc_data;
          sc_ptr <= sc_ptr + AW'(1);
          state <= (sc_ptr + AW'(1) == sc_end) ? S_FILL : S_SRD;
        end
        S_FILL: begin
          screen[sc_ptr] <= space_cell;
          sc_ptr <= sc_ptr + AW'(1);
          if (sc_ptr + AW'(1) == sc_total) state <= S_ONE;
        end
        S_FONT: begin
          bits <= in_glyph ? font[{cell_q[7:0], crow}] : 8'd0;
          fgc <= pal_rd(palette[fsel], fsel);
          bgc <= pal_rd(palette[bsel], bsel);
          state <= S_PIX;
        end
        S_PIX: begin
          m_tvalid <= 1'b1;
          m_tdata[15:0] <= ok ? (bits[{sh, 1'b1}] ? fgc : bgc) : 16'd0;
          m_tdata[31:16] <= ok ? (bits[{sh, 1'b0}] ? fgc : bgc) : 16'd0;
          m_tlast <= (k == 2'd3);
          m_tuser <= !ok;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_fire) begin
            m_tvalid <= 1'b0;
            k <= k + 2'd1;
            state <= m_tlast ? S_IDLE : S_PIX;
          end
        end
        S_ONE: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= '0;
            m_tlast <= 1'b1;
            m_tuser <= status;
          end else if (out_fire) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMT_ASSERT(a_ready_idle, s_tready |-> !m_tvalid, "input taken while result pending")
  `TMT_ASSERT(a_au_done, au_stat.busy |=> au_stat.done, "address unit lost a request")
  `TMT_ASSERT(a_valid_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")

endmodule

// File: design/tmt_addr_unit.sv
// Shared multiply-add unit: computes row * cols + col and registers the
// result when start is high. Used by write, render and scroll addressing.
module tmt_addr_unit #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [4:0]    row,
  input  logic [6:0]    cols,
  input  logic [6:0]    col,
  output logic [AW-1:0] addr,
  output tmt_pkg::addr_stat_t stat
);
  import tmt_pkg::*;

  logic [11:0] prod;
  logic        done;

  assign prod = 12'(row) * 12'(cols) + 12'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      addr <= AW'(prod);
    end
  end

  assign stat.busy = start;
  assign stat.done = done;

endmodule

// File: test/tb_text_mode_terminal_renderer.sv
`timescale 1ns / 100ps

module tb_text_mode_terminal_renderer;
  import tmt_pkg::*;

  localparam int MaxCols = 80;
  localparam int MaxRows = 30;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [15:0] pix_l;
    logic [15:0] pix_r;
    logic        last;
    logic        st;
  } pix_pair_t;

  typedef struct {
    logic [63:0] data;
    bit          typed;
    logic        st;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  text_mode_terminal_renderer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the terminal
  logic [15:0] scr [MaxCols * MaxRows];
  logic [7:0]  font [2048];
  logic [15:0] pal [16];
  int unsigned cur_col, cur_row;
  int unsigned r_cols, r_rows, r_scroll, r_fg, r_bg, r_first, r_last;

  // character codes that writes use; their glyphs are loaded before the tests
  logic [7:0] glyph_set [8];

  pix_pair_t pending_pix[$];
  int errors, n_items, n_results, n_cfg, n_scrolls, n_renders, n_offscreen;
  bit quiet;
  int idle_cnt;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_cols();
    if (r_cols == 0) return 1;
    return r_cols > MaxCols ? MaxCols : r_cols;
  endfunction

  function automatic int eff_rows();
    if (r_rows == 0) return 1;
    return r_rows > MaxRows ? MaxRows : r_rows;
  endfunction

  function automatic logic [15:0] cell_of(logic [7:0] code);
    return {r_bg[3:0], r_fg[3:0], code};
  endfunction

  function automatic logic [63:0] pack(mode_t m, logic [7:0] code, logic [7:0] drow,
                                       logic [6:0] tcol, logic [10:0] faddr,
                                       logic [7:0] fbits, logic [3:0] pslot,
                                       logic [15:0] pcol);
    return {pcol, pslot, fbits, faddr, tcol, drow, code, m};
  endfunction

  // compute the pixel pairs an accepted request produces and update the shadow
  task automatic predict_pixels(input logic [63:0] d, output pix_pair_t res[4],
                                output int n);
    mode_t m;
    int cols, rows, trow, crow, tcol, i;
    logic [15:0] sc_word, fgc, bgc;
    logic [7:0] bits;
    logic [3:0] fi, bi;
    bit ok, at_cur;
    m = mode_t'(d[1:0]);
    cols = eff_cols();
    rows = eff_rows();
    for (i = 0; i < 4; i++) res[i] = '{16'h0, 16'h0, 1'b1, 1'b0};
    n = 1;
    case (m)
      MODE_WRITE: begin
        if (cur_col >= cols || cur_row >= rows) begin
          cur_col = 0;
          cur_row = 0;
          res[0].st = 1'b1;
        end else begin
          scr[cur_row * cols + cur_col] = cell_of(d[9:2]);
          cur_col++;
          if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows) begin
              if (r_scroll[0]) begin
                cur_row = rows - 1;
                for (i = 0; i < (rows - 1) * cols; i++) scr[i] = scr[i + cols];
                for (i = 0; i < cols; i++) scr[(rows - 1) * cols + i] = cell_of(SpaceCode);
                n_scrolls++;
              end else begin
                cur_row = 0;
              end
            end
          end
        end
      end
      MODE_FONT: font[d[35:25]] = d[43:36];
      MODE_PAL: pal[d[47:44]] = d[63:48];
      default: begin
        n = 4;
        n_renders++;
        trow = d[17:13];
        crow = d[12:10];
        tcol = d[24:18];
        ok = (trow < rows) && (tcol < cols);
        bits = 8'h00;
        fgc = 16'h0;
        bgc = 16'h0;
        if (ok) begin
          sc_word = scr[trow * cols + tcol];
          at_cur = (cur_col == tcol) && (cur_row == trow);
          fi = sc_word[11:8];
          bi = sc_word[15:12];
          fgc = pal[at_cur ? bi : fi];
          bgc = pal[at_cur ? fi : bi];
          if (sc_word[7:0] >= r_first && sc_word[7:0] <= r_last)
            bits = font[{sc_word[7:0], crow[2:0]}];
        end else begin
          n_offscreen++;
        end
        for (i = 0; i < 4; i++) begin
          res[i].pix_l = ok ? (bits[7 - 2 * i] ? fgc : bgc) : 16'h0;
          res[i].pix_r = ok ? (bits[6 - 2 * i] ? fgc : bgc) : 16'h0;
          res[i].last = (i == 3);
          res[i].st = !ok;
        end
      end
    endcase
  endtask

  // request with optional leading gap; valid stays high between back-to-back requests
  task automatic send_item(input logic [63:0] d, input bit typed, input logic st);
    pix_pair_t res[4];
    int n, g, i;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, d[63:2]};
    s_tuser <= d[1:0];
    do @(posedge clk); while (!s_tready);
    n_items++;
    predict_pixels(d, res, n);
    for (i = 0; i < n; i++) begin
      if (typed) begin
        res[i].pix_l = 16'h0;
        res[i].pix_r = 16'h0;
        res[i].last = (i == n - 1);
        res[i].st = st;
      end
      pending_pix.push_back(res[i]);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    // block back in idle before touching the registers
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    case (idx)
      REG_COLS:   r_cols = v[6:0];
      REG_ROWS:   r_rows = v[4:0];
      REG_SCROLL: r_scroll = v[0];
      REG_FG:     r_fg = v[3:0];
      REG_BG:     r_bg = v[3:0];
      REG_FIRST:  r_first = v;
      default:    r_last = v;
    endcase
  endtask

  task automatic set_screen(input int c, input int r, input int sc, input int fg,
                            input int bg, input int fi, input int la);
    write_reg(REG_COLS, 8'(c));
    write_reg(REG_ROWS, 8'(r));
    write_reg(REG_SCROLL, 8'(sc));
    write_reg(REG_FG, 8'(fg));
    write_reg(REG_BG, 8'(bg));
    write_reg(REG_FIRST, 8'(fi));
    write_reg(REG_LAST, 8'(la));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_item();
    logic [63:0] d;
    int r, cols, rows;
    d = {$urandom, $urandom};
    cols = eff_cols();
    rows = eff_rows();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      d[1:0] = MODE_WRITE;
      d[9:2] = glyph_set[$urandom_range(0, 7)];
    end else if (r < 85) begin
      d[1:0] = MODE_RENDER;
      r = $urandom_range(0, 9);
      if (r < 3) begin
        d[17:10] = {cur_row[4:0], d[12:10]};
        d[24:18] = cur_col[6:0];
      end else if (r < 8) begin
        d[17:10] = 8'($urandom_range(0, rows * 8 - 1));
        d[24:18] = 7'($urandom_range(0, cols - 1));
      end
    end else if (r < 95) begin
      d[1:0] = MODE_FONT;
    end else begin
      d[1:0] = MODE_PAL;
    end
    return d;
  endfunction

  // result side: random back-pressure
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pix_pair_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_pix.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pl=%h pr=%h last=%b st=%b", $realtime,
                 m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser);
      end else begin
        e = pending_pix.pop_front();
        if (m_tdata[15:0] !== e.pix_l || m_tdata[31:16] !== e.pix_r ||
            m_tlast !== e.last || m_tuser !== e.st) begin
          errors++;
          $display("%0t: mismatch exp pl=%h pr=%h last=%b st=%b got pl=%h pr=%h last=%b st=%b",
                   $realtime, e.pix_l, e.pix_r, e.last, e.st,
                   m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("%0t: timeout, %0d results outstanding", $realtime, pending_pix.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    int i, ph, k, n_ph;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COLS;
    cfg_data = '0;
    quiet = 1'b0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_cfg = 0;
    n_scrolls = 0;
    n_renders = 0;
    n_offscreen = 0;
    idle_cnt = 0;
    glyph_set = '{8'h00, 8'h20, 8'h41, 8'h42, 8'h5a, 8'h7e, 8'h7f, 8'hff};
    for (i = 0; i < MaxCols * MaxRows; i++) scr[i] = 16'h0;
    for (i = 0; i < 2048; i++) font[i] = 8'h0;
    for (i = 0; i < 16; i++) pal[i] = 16'h0;
    cur_col = 0;
    cur_row = 0;
    r_cols = 80;
    r_rows = 30;
    r_scroll = 1;
    r_fg = 15;
    r_bg = 0;
    r_first = 32;
    r_last = 126;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // load the palette and the glyphs of every code a write can store, so no
    // render reads an unwritten entry
    quiet = 1'b1;
    for (i = 0; i < 16; i++)
      send_item(pack(MODE_PAL, 0, 0, 0, 0, 0, 4'(i), 16'($urandom)), 1'b0, 1'b0);
    for (i = 0; i < 8; i++)
      for (k = 0; k < 8; k++)
        send_item(pack(MODE_FONT, 0, 0, 0, {glyph_set[i], 3'(k)}, 8'($urandom), 0, 0),
                  1'b0, 1'b0);
    quiet = 1'b0;

    // directed table
    dir_rows.push_back('{pack(MODE_PAL, 0, 0, 0, 0, 0, 4'd0, 16'h0000), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_PAL, 0, 0, 0, 0, 0, 4'd15, 16'hffff), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_FONT, 0, 0, 0, 11'd0, 8'hff, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_FONT, 0, 0, 0, 11'd2047, 8'h00, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_FONT, 0, 0, 0, 11'h208, 8'ha5, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd0, 7'd0, 0, 0, 0, 0), 0, 1'b0});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd239, 7'd79, 0, 0, 0, 0), 0, 1'b0});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd240, 7'd0, 0, 0, 0, 0), 1, 1'b1});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd255, 7'd127, 0, 0, 0, 0), 1, 1'b1});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd0, 7'd80, 0, 0, 0, 0), 1, 1'b1});
    dir_rows.push_back('{pack(MODE_WRITE, 8'h41, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_WRITE, 8'h00, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_WRITE, 8'hff, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_WRITE, 8'h7e, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    dir_rows.push_back('{pack(MODE_WRITE, 8'h20, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    for (k = 0; k < 8; k++)
      dir_rows.push_back('{pack(MODE_RENDER, 0, 8'(k), 7'd0, 0, 0, 0, 0), 0, 1'b0});
    // cursor cell with swapped colors, then glyph below range
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd3, 7'd5, 0, 0, 0, 0), 0, 1'b0});
    dir_rows.push_back('{pack(MODE_RENDER, 0, 8'd1, 7'd1, 0, 0, 0, 0), 0, 1'b0});
    foreach (dir_rows[j]) send_item(dir_rows[j].data, dir_rows[j].typed, dir_rows[j].st);

    n_ph = 12;
    for (ph = 0; ph < n_ph; ph++) begin
      wait_idle();
      case (ph)
        0: set_screen(80, 30, 1, 15, 0, 32, 126);
        1: set_screen(0, 0, 1, 0, 15, 0, 255);
        2: set_screen(127, 31, 0, 15, 15, 255, 0);
        3: set_screen(1, 1, 0, 3, 12, 0, 255);
        4: set_screen(3, 2, 1, 9, 6, 0, 255);
        default: set_screen($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 8),
                            $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 4),
                            $urandom_range(0, 1), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 80),
                            $urandom_range(60, 255));
      endcase
      quiet = (ph % 4 == 3);
      for (k = 0; k < 30; k++) send_item(rand_item(), 1'b0, 1'b0);
      quiet = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d requests (%0d renders, %0d off screen), %0d results",
             n_items, n_renders, n_offscreen, n_results);
    $display("with %0d register writes and %0d scrolls", n_cfg, n_scrolls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/tmt_pkg.sv
design/tmt_addr_unit.sv
design/text_mode_terminal_renderer.sv
test/tb_text_mode_terminal_renderer.sv
